>>> hdl/skw_pkg.sv
// Shared types, widths and constants for the swerve drive inverse kinematics block.
// No dependencies; every other file imports this package.
package skw_pkg;

  localparam int VW         = 16;
  localparam int CFGW       = 16;
  localparam int CIW        = 2;
  localparam int PRODW      = 33;
  localparam int XW         = 22;
  localparam int SQW        = 2 * XW;
  localparam int RW         = XW;
  localparam int SQ_STAGES  = RW;
  localparam int RMW        = RW + 3;
  localparam int CW         = 45;
  localparam int ZW         = 34;
  localparam int SPW        = 18;
  localparam int ANW        = 16;
  localparam int AW         = 19;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFGW-1:0] CHASSIS_RESET = 16'd1024;

  typedef enum logic [CIW-1:0] {
    CFG_CHASSIS_LENGTH = 2'd0,
    CFG_CHASSIS_WIDTH  = 2'd1
  } skw_cfg_idx_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
  } skw_vec_t;

  typedef struct packed {
    skw_vec_t fl;
    skw_vec_t fr;
    skw_vec_t rl;
    skw_vec_t rr;
  } skw_wheels_t;

  // atan(2^-i) with LSB pi/2^31
  function automatic logic signed [ZW-1:0] atan_lut(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/skw_if.sv
// Valid/ready channel interfaces for chassis commands and wheel results.
// Depends on skw_pkg.
interface skw_in_if;
  import skw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] vel_x;
  logic signed [VW-1:0] vel_y;
  logic signed [VW-1:0] yaw_rate;
  modport source(output valid, output vel_x, output vel_y, output yaw_rate, input ready);
  modport sink(input valid, input vel_x, input vel_y, input yaw_rate, output ready);
endinterface

interface skw_out_if;
  import skw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [SPW-1:0] front_left_speed;
  logic signed [ANW-1:0] front_left_angle;
  logic signed [SPW-1:0] front_right_speed;
  logic signed [ANW-1:0] front_right_angle;
  logic signed [SPW-1:0] rear_left_speed;
  logic signed [ANW-1:0] rear_left_angle;
  logic signed [SPW-1:0] rear_right_speed;
  logic signed [ANW-1:0] rear_right_angle;
  modport source(output valid, output front_left_speed, output front_left_angle,
                 output front_right_speed, output front_right_angle,
                 output rear_left_speed, output rear_left_angle,
                 output rear_right_speed, output rear_right_angle, input ready);
  modport sink(input valid, input front_left_speed, input front_left_angle,
               input front_right_speed, input front_right_angle,
               input rear_left_speed, input rear_left_angle,
               input rear_right_speed, input rear_right_angle, output ready);
endinterface

>>> hdl/skw_front.sv
// Front end: accepts chassis commands, forms omega*L and omega*W, then the
// rounded per-wheel x/y components. Depends on skw_pkg and skw_if.
module skw_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [skw_pkg::CFGW-1:0]   chassis_length,
  input  logic [skw_pkg::CFGW-1:0]   chassis_width,
  skw_in_if.sink                     in_ch,
  output logic                       push_valid,
  input  logic                       push_ready,
  output skw_pkg::skw_wheels_t       push_data
);
  import skw_pkg::*;

  logic                    f_valid_r;
  logic signed [VW-1:0]    vx_r, vy_r;
  logic signed [PRODW-1:0] wl_r, ww_r;

  function automatic logic signed [XW-1:0] comp(input logic signed [VW-1:0] b,
                                                input logic signed [PRODW-1:0] d,
                                                input logic sub);
    logic signed [PRODW:0] t;
    t = (($signed((PRODW+1)'(b))) <<< 11) + (sub ? -(PRODW+1)'(d) : (PRODW+1)'(d))
        + (PRODW+1)'(1024);
    return t[XW+10:11];
  endfunction

  assign in_ch.ready = !f_valid_r || push_ready;
  assign push_valid  = f_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      f_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      vx_r <= in_ch.vel_x;
      vy_r <= in_ch.vel_y;
      wl_r <= in_ch.yaw_rate * $signed({1'b0, chassis_length});
      ww_r <= in_ch.yaw_rate * $signed({1'b0, chassis_width});
    end
  end

  always_comb begin
    push_data.fl.x = comp(vx_r, wl_r, 1'b1);
    push_data.fl.y = comp(vy_r, ww_r, 1'b0);
    push_data.fr.x = comp(vx_r, wl_r, 1'b0);
    push_data.fr.y = comp(vy_r, ww_r, 1'b0);
    push_data.rl.x = comp(vx_r, wl_r, 1'b1);
    push_data.rl.y = comp(vy_r, ww_r, 1'b1);
    push_data.rr.x = comp(vx_r, wl_r, 1'b0);
    push_data.rr.y = comp(vy_r, ww_r, 1'b1);
  end

endmodule

>>> hdl/skw_fifo.sv
// Short queue of wheel component sets between front and back end.
// Depends on skw_pkg.
module skw_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  skw_pkg::skw_wheels_t  push_data,
  output logic                  pop_valid,
  input  logic                  pop,
  output skw_pkg::skw_wheels_t  pop_data
);
  import skw_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  skw_wheels_t   mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != (PW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

>>> hdl/skw_wheel.sv
// One wheel of the back end: squares, pipelined square root and CORDIC
// vectoring side by side, then angle fold and speed saturation. Depends on skw_pkg.
module skw_wheel #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  skw_pkg::skw_vec_t             vec,
  output logic signed [skw_pkg::SPW-1:0] speed,
  output logic signed [skw_pkg::ANW-1:0] angle
);
  import skw_pkg::*;

  localparam int P = (CORDIC_STAGES > SQ_STAGES) ? CORDIC_STAGES : SQ_STAGES;

  logic signed [XW-1:0]  x0_r, y0_r;
  logic [SQW-1:0]        n_r    [P+1];
  logic [RMW-1:0]        rem_r  [P+1];
  logic [RW-1:0]         root_r [P+1];
  logic signed [CW-1:0]  cx_r   [P+1];
  logic signed [CW-1:0]  cy_r   [P+1];
  logic signed [ZW-1:0]  cz_r   [P+1];
  logic                  zero_r [P+1];

  logic signed [2*XW-1:0] xx, yy;
  logic signed [CW-1:0]   xe, ye;
  logic                   neg;

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= vec.x;
      y0_r <= vec.y;
    end
  end

  always_comb begin
    xx  = x0_r * x0_r;
    yy  = y0_r * y0_r;
    xe  = CW'(x0_r);
    ye  = CW'(y0_r);
    neg = x0_r < 0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= $unsigned(xx) + $unsigned(yy);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      cx_r[0]   <= (neg ? -xe : xe) <<< 20;
      cy_r[0]   <= (neg ? -ye : ye) <<< 20;
      cz_r[0]   <= !neg ? '0 : (y0_r >= 0) ? ZW'(64'sd2147483648) : -ZW'(64'sd2147483648);
      zero_r[0] <= (x0_r == '0) && (y0_r == '0);
    end
  end

  for (genvar i = 0; i < P; i++) begin : g_stage
    if (i < SQ_STAGES) begin : g_sq
      logic [RMW-1:0] remn, t;
      assign remn = {rem_r[i][RMW-3:0], n_r[i][SQW-1:SQW-2]};
      assign t    = RMW'({root_r[i], 2'b01});
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[i+1] <= n_r[i] << 2;
          if (remn >= t) begin
            rem_r[i+1]  <= remn - t;
            root_r[i+1] <= {root_r[i][RW-2:0], 1'b1};
          end else begin
            rem_r[i+1]  <= remn;
            root_r[i+1] <= {root_r[i][RW-2:0], 1'b0};
          end
        end
      end
    end else begin : g_sq_hold
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[i+1]    <= n_r[i];
          rem_r[i+1]  <= rem_r[i];
          root_r[i+1] <= root_r[i];
        end
      end
    end

    if (i < CORDIC_STAGES) begin : g_cr
      logic signed [CW-1:0] dx, dy;
      assign dx = cy_r[i] >>> i;
      assign dy = cx_r[i] >>> i;
      always_ff @(posedge clk) begin
        if (en) begin
          if (cy_r[i] > 0) begin
            cx_r[i+1] <= cx_r[i] + dx;
            cy_r[i+1] <= cy_r[i] - dy;
            cz_r[i+1] <= cz_r[i] + atan_lut(i);
          end else begin
            cx_r[i+1] <= cx_r[i] - dx;
            cy_r[i+1] <= cy_r[i] + dy;
            cz_r[i+1] <= cz_r[i] - atan_lut(i);
          end
          zero_r[i+1] <= zero_r[i];
        end
      end
    end else begin : g_cr_hold
      always_ff @(posedge clk) begin
        if (en) begin
          cx_r[i+1]   <= cx_r[i];
          cy_r[i+1]   <= cy_r[i];
          cz_r[i+1]   <= cz_r[i];
          zero_r[i+1] <= zero_r[i];
        end
      end
    end
  end

  logic [RW:0]          mag;
  logic signed [ZW:0]   za;
  logic signed [AW-1:0] a0, a1, a2, d;
  logic signed [RW+1:0] s0, s1, s2;
  logic signed [SPW-1:0] s_sat;

  always_comb begin
    mag = (RW+1)'(root_r[P]) + (RW+1)'(rem_r[P] > RMW'(root_r[P]));
    za  = (ZW+1)'(32768) - (zero_r[P] ? '0 : (ZW+1)'(cz_r[P]));
    a0  = AW'(za >>> 16);
    s0  = $signed({1'b0, mag});
    if (a0 > AW'(16384)) begin
      a1 = a0 - AW'(32768);
      s1 = -s0;
    end else if (a0 < -AW'(16384)) begin
      a1 = a0 + AW'(32768);
      s1 = -s0;
    end else begin
      a1 = a0;
      s1 = s0;
    end
    d = a1 + AW'(16384);
    if (d <= AW'(10) && d >= -AW'(10)) begin
      a2 = -a1;
      s2 = -s1;
    end else begin
      a2 = a1;
      s2 = s1;
    end
    if (s2 > (RW+2)'(131071)) s_sat = SPW'(131071);
    else if (s2 < -(RW+2)'(131072)) s_sat = SPW'(-131072);
    else s_sat = SPW'(s2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      speed <= s_sat;
      angle <= ANW'(a2);
    end
  end

endmodule

>>> hdl/skw_back.sv
// Back end: four wheel pipelines under one stall enable, with the valid chain
// and the result register. Depends on skw_pkg, skw_if and skw_wheel.
module skw_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop,
  input  skw_pkg::skw_wheels_t  pop_data,
  skw_out_if.source             out_ch
);
  import skw_pkg::*;

  localparam int P = (CORDIC_STAGES > SQ_STAGES) ? CORDIC_STAGES : SQ_STAGES;
  localparam int L = P + 3;

  logic [L-1:0] v_r;
  logic         adv;

  assign adv          = !v_r[L-1] || out_ch.ready;
  assign pop          = adv && pop_valid;
  assign out_ch.valid = v_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[L-2:0], pop_valid};
    end
  end

  skw_wheel #(.CORDIC_STAGES(CORDIC_STAGES)) u_fl (
    .clk(clk), .en(adv), .vec(pop_data.fl),
    .speed(out_ch.front_left_speed), .angle(out_ch.front_left_angle));
  skw_wheel #(.CORDIC_STAGES(CORDIC_STAGES)) u_fr (
    .clk(clk), .en(adv), .vec(pop_data.fr),
    .speed(out_ch.front_right_speed), .angle(out_ch.front_right_angle));
  skw_wheel #(.CORDIC_STAGES(CORDIC_STAGES)) u_rl (
    .clk(clk), .en(adv), .vec(pop_data.rl),
    .speed(out_ch.rear_left_speed), .angle(out_ch.rear_left_angle));
  skw_wheel #(.CORDIC_STAGES(CORDIC_STAGES)) u_rr (
    .clk(clk), .en(adv), .vec(pop_data.rr),
    .speed(out_ch.rear_right_speed), .angle(out_ch.rear_right_angle));

endmodule

>>> hdl/swerve_drive_inverse_kinematics.sv
// Top level of the four-wheel swerve drive inverse kinematics block.
// Depends on skw_pkg, skw_if, skw_front, skw_fifo and skw_back.
//
// Usage:
//   in_ch carries one chassis command (vel_x, vel_y, yaw_rate, Q5.10) per
//   transaction; out_ch carries one result per command: signed speed (Q7.10,
//   saturated) and steer angle (LSB pi/32768, within +-pi/2) for each wheel.
//   cfg_we/cfg_index/cfg_wdata write chassis_length (index 0) and
//   chassis_width (index 1); other indexes are ignored. Write only while idle.
//   Throughput: one command per cycle unless out_ch.ready stalls the back
//   pipeline. Each command passes the front stage, which loads on the
//   accepting edge, then the queue, one component stage, one squaring
//   stage, the 22-step square root and the CORDIC run side by side,
//   then the fold/result register.
//   Reset clears all valids and the queue and sets both chassis dimensions to
//   1.0 m. When out_ch.ready is low the back pipeline holds; the four-entry
//   queue and the front stage keep accepting until they fill, then in_ch.ready
//   drops.
module swerve_drive_inverse_kinematics #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [skw_pkg::CIW-1:0]  cfg_index,
  input  logic [skw_pkg::CFGW-1:0] cfg_wdata,
  skw_in_if.sink                   in_ch,
  skw_out_if.source                out_ch
);
  import skw_pkg::*;

  logic [CFGW-1:0] length_r, width_r;
  logic            push_valid, push_ready, pop_valid, pop;
  skw_wheels_t     push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= CHASSIS_RESET;
      width_r  <= CHASSIS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHASSIS_LENGTH: length_r <= cfg_wdata;
        CFG_CHASSIS_WIDTH:  width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  skw_front u_front (
    .clk(clk), .rst_n(rst_n), .chassis_length(length_r), .chassis_width(width_r),
    .in_ch(in_ch), .push_valid(push_valid), .push_ready(push_ready),
    .push_data(push_data));

  skw_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push_valid(push_valid), .push_ready(push_ready),
    .push_data(push_data), .pop_valid(pop_valid), .pop(pop), .pop_data(pop_data));

  skw_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst_n(rst_n), .pop_valid(pop_valid), .pop(pop),
    .pop_data(pop_data), .out_ch(out_ch));

endmodule

>>> hdl/skw_checker.sv
// Port-level checks on the result channel of the swerve kinematics block.
// Depends on skw_pkg; bound to swerve_drive_inverse_kinematics.
module skw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [skw_pkg::ANW-1:0] fl_angle,
  input logic signed [skw_pkg::ANW-1:0] fr_angle,
  input logic signed [skw_pkg::ANW-1:0] rl_angle,
  input logic signed [skw_pkg::ANW-1:0] rr_angle
);
  import skw_pkg::*;

  function automatic logic ang_ok(input logic signed [ANW-1:0] a);
    return (a <= 16'sd16384) && (a >= -16'sd16384) &&
           !((a >= -16'sd16394) && (a <= -16'sd16374));
  endfunction

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(fl_angle) && $stable(rr_angle))
    else $error("stalled result changed");

  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ang_ok(fl_angle) && ang_ok(fr_angle))
    else $error("front angle outside folded range");

  a_rear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ang_ok(rl_angle) && ang_ok(rr_angle))
    else $error("rear angle outside folded range");

endmodule

bind swerve_drive_inverse_kinematics skw_checker u_skw_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .fl_angle(out_ch.front_left_angle), .fr_angle(out_ch.front_right_angle),
  .rl_angle(out_ch.rear_left_angle), .rr_angle(out_ch.rear_right_angle));
